### src/page_framebuffer_draw_engine_defines.svh
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// check that cons holds whenever ante holds
`define PFDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cond never holds
`define PFDE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### src/pfde_pkg.sv
package pfde_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_ROWS    = 32;
  localparam int PAGE_ROWS      = 8;
  localparam int PAGE_COUNT     = (SCREEN_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES    = SCREEN_COLUMNS * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_BYTES);
  localparam int COL_W          = $clog2(SCREEN_COLUMNS);
  localparam int PAGE_W         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       pixel_value;
    logic [8:0] byte_index;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] byte_data;
    logic       clipped;
  } draw_rsp_t;

endpackage

### src/pfde_ram.sv
module pfde_ram
  import pfde_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  addr_t      wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  addr_t      rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/page_framebuffer_draw_engine.sv
// Monochrome 128x32 frame store in 8-row pages (byte = x + (y/8)*128, bit = y mod 8)
// with a small draw engine. Each request returns exactly one response. Pixel and
// read-byte requests do one memory read, then the write-back or capture.
// Rectangle and clear requests sweep the whole 512-byte store at one byte per cycle
// through the store's single read and single write port (a clear only writes);
// a rectangle recomputes all 8 pixels of each byte as it streams by. After reset a
// clearing pass runs with in_ready low. A finished response is
// held in the output register while the next request is accepted.
`include "page_framebuffer_draw_engine_defines.svh"

module page_framebuffer_draw_engine
  import pfde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  draw_req_t in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output draw_rsp_t out_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_WALK,
    ST_POST
  } state_t;

  state_t             state_r;
  draw_req_t          req_r;
  logic               clip_r;
  logic               wipe_r;
  logic               init_r;
  addr_t              addr_r;
  logic [COL_W-1:0]   col_r;
  logic [PAGE_W-1:0]  page_r;
  logic               issue_done_r;
  logic               s1_v_r;
  addr_t              s1_addr_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [PAGE_W-1:0]  s1_page_r;
  logic               out_valid_r;
  draw_rsp_t          out_rsp_r;
  draw_rsp_t          res_r;

  logic               in_acc;
  logic               slot_free;
  logic               done;
  draw_rsp_t          res_nxt;
  addr_t              pix_addr;
  addr_t              idx_addr;
  logic               acc_clip;
  logic               rect_clip;
  logic               rd_en;
  addr_t              rd_addr;
  logic [7:0]         rd_data;
  logic               wr_en;
  addr_t              wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         pix_byte;
  logic [7:0]         rect_byte;

  function automatic logic span_off(logic [7:0] s, logic [7:0] len, int lim);
    return (len != 8'd0) && ((int'(s) + int'(len)) > lim);
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign pix_addr = ADDR_W'(int'(in_req.x_pos) + int'(in_req.y_pos[7:3]) * SCREEN_COLUMNS);
  assign idx_addr = ADDR_W'(in_req.byte_index);

  always_comb begin
    rect_clip =
      ((in_req.rect_width != 8'd0) &&
       ((int'(in_req.y_pos) >= SCREEN_ROWS) ||
        (int'(8'(in_req.y_pos + in_req.rect_height)) >= SCREEN_ROWS) ||
        span_off(in_req.x_pos, in_req.rect_width, SCREEN_COLUMNS))) ||
      ((in_req.rect_height != 8'd0) &&
       ((int'(in_req.x_pos) >= SCREEN_COLUMNS) ||
        (int'(8'(in_req.x_pos + in_req.rect_width)) >= SCREEN_COLUMNS) ||
        span_off(in_req.y_pos, in_req.rect_height, SCREEN_ROWS)));
    case (in_req.opcode)
      OP_PIXEL: acc_clip = (int'(in_req.x_pos) >= SCREEN_COLUMNS) ||
                           (int'(in_req.y_pos) >= SCREEN_ROWS);
      OP_RECT:  acc_clip = rect_clip;
      OP_CLEAR: acc_clip = 1'b0;
      OP_READ:  acc_clip = int'(in_req.byte_index) >= STORE_BYTES;
      default:  acc_clip = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_r;
    if (state_r == ST_IDLE) begin
      rd_en   = in_acc && ((in_req.opcode == OP_PIXEL) || (in_req.opcode == OP_READ));
      rd_addr = (in_req.opcode == OP_READ) ? idx_addr : pix_addr;
    end else if (state_r == ST_WALK) begin
      rd_en   = !issue_done_r && !wipe_r;
    end
  end

  always_comb begin
    pix_byte = rd_data;
    pix_byte[req_r.y_pos[2:0]] = req_r.pixel_value;
  end

  // recompute each pixel of the streamed byte: interior wins, then outline
  always_comb begin
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] dx;
    logic [7:0] dy;
    logic       x_in;
    logic       y_in;
    logic       inter;
    logic       outl;
    px        = 8'(s1_col_r);
    py        = 8'd0;
    dx        = 8'd0;
    dy        = 8'd0;
    x_in      = 1'b0;
    y_in      = 1'b0;
    inter     = 1'b0;
    outl      = 1'b0;
    rect_byte = rd_data;
    for (int b = 0; b < PAGE_ROWS; b++) begin
      py    = 8'(int'(s1_page_r) * PAGE_ROWS + b);
      dx    = px - req_r.x_pos;
      dy    = py - req_r.y_pos;
      x_in  = dx < req_r.rect_width;
      y_in  = dy < req_r.rect_height;
      inter = (dx != 8'd0) && x_in && (dy != 8'd0) && y_in;
      outl  = ((dy == 8'd0) && x_in) || ((dy == req_r.rect_height) && x_in) ||
              ((dx == req_r.rect_width) && y_in) || ((dx == 8'd0) && y_in);
      if (int'(py) < SCREEN_ROWS) begin
        if (inter) begin
          rect_byte[b] = req_r.pixel_value;
        end else if (outl) begin
          rect_byte[b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr_r;
    wr_data = wipe_r ? 8'd0 : rect_byte;
    if (state_r == ST_RMW) begin
      wr_en   = (req_r.opcode == OP_PIXEL) && !clip_r;
      wr_addr = addr_r;
      wr_data = pix_byte;
    end else if (s1_v_r) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    done              = (state_r == ST_RMW) ||
                        ((state_r == ST_WALK) && issue_done_r && !s1_v_r && !init_r);
    res_nxt.clipped   = clip_r;
    res_nxt.byte_data = ((state_r == ST_RMW) && (req_r.opcode == OP_READ) && !clip_r) ?
                        rd_data : 8'd0;
  end

  pfde_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WALK;
      wipe_r       <= 1'b1;
      init_r       <= 1'b1;
      addr_r       <= '0;
      col_r        <= '0;
      page_r       <= '0;
      issue_done_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ST_WALK) && !issue_done_r;
      if ((done || (state_r == ST_POST)) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r        <= in_req;
            clip_r       <= acc_clip;
            wipe_r       <= (in_req.opcode == OP_CLEAR);
            addr_r       <= (in_req.opcode == OP_PIXEL) ? pix_addr : '0;
            col_r        <= '0;
            page_r       <= '0;
            issue_done_r <= 1'b0;
            if ((in_req.opcode == OP_PIXEL) || (in_req.opcode == OP_READ)) begin
              state_r <= ST_RMW;
            end else begin
              state_r <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (!issue_done_r) begin
            s1_addr_r <= addr_r;
            s1_col_r  <= col_r;
            s1_page_r <= page_r;
            addr_r    <= addr_r + ADDR_W'(1);
            if (col_r == COL_W'(SCREEN_COLUMNS - 1)) begin
              col_r  <= '0;
              page_r <= page_r + PAGE_W'(1);
            end else begin
              col_r <= col_r + COL_W'(1);
            end
            if (addr_r == ADDR_W'(STORE_BYTES - 1)) begin
              issue_done_r <= 1'b1;
            end
          end else if (!s1_v_r && init_r) begin
            init_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        ST_POST: begin
          if (slot_free) begin
            out_rsp_r <= res_r;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (done) begin
        res_r <= res_nxt;
        if (slot_free) begin
          out_rsp_r <= res_nxt;
          state_r   <= ST_IDLE;
        end else begin
          state_r <= ST_POST;
        end
      end
    end
  end

  `PFDE_ASSERT_NEVER(a_rd_wr_same, wr_en && rd_en && (wr_addr == rd_addr), "read write clash")
  `PFDE_ASSERT_IMPL(a_s1_in_walk, s1_v_r, state_r == ST_WALK, "sweep write outside sweep")
  `PFDE_ASSERT_IMPL(a_init_blocks, init_r, !in_ready, "request taken during clearing pass")
  `PFDE_ASSERT_IMPL(a_rmw_after_acc, state_r == ST_RMW, $past(in_acc), "stray byte access")
  `PFDE_ASSERT_IMPL(a_clip_no_wr, (state_r == ST_RMW) && clip_r, !wr_en, "off-screen write")

endmodule
